>>> hdl/segisect_pkg.sv
// Shared constants and register map for the 2D segment intersection block.
// No dependencies; imported by segment_intersection_2d.
package segisect_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	localparam logic [CFG_DATA_W-1:0] TOUCH_EPS_RST    = 32'd1;
	localparam logic [CFG_DATA_W-1:0] PARALLEL_EPS_RST = 32'd1;

	typedef enum logic {
		REG_TOUCH_EPS    = 1'b0,
		REG_PARALLEL_EPS = 1'b1
	} reg_idx_t;

endpackage

>>> hdl/segment_intersection_2d.sv
// 2D segment pair intersection: side tests, reject checks and a pipelined
// restoring divider giving the crossing point in fixed point.
// Depends on segisect_pkg.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in       | in        | in_valid / in_stall   | a_/b_ start/end x/y coords
//  out      | out       | out_valid / out_stall | status, hit_x, hit_y
//  config   | in        | APB psel/penable      | touch_eps (0x0), parallel_eps (0x4)
//
// One item enters per cycle except while the pipeline holds. The divider
// retires one quotient bit per stage, and the whole pipeline holds while a
// result waits under out_stall.
// Reset clears the valid bits and loads both thresholds with 1.
module segment_intersection_2d #(
	parameter int COORD_BITS = segisect_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = segisect_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_BITS-1:0]         a_start_x,
	input  logic signed [COORD_BITS-1:0]         a_start_y,
	input  logic signed [COORD_BITS-1:0]         a_end_x,
	input  logic signed [COORD_BITS-1:0]         a_end_y,
	input  logic signed [COORD_BITS-1:0]         b_start_x,
	input  logic signed [COORD_BITS-1:0]         b_start_y,
	input  logic signed [COORD_BITS-1:0]         b_end_x,
	input  logic signed [COORD_BITS-1:0]         b_end_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 status,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] hit_x,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] hit_y,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [segisect_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [segisect_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [segisect_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready
);
	import segisect_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;          // coordinate differences
	localparam int PW  = 2 * C + 2;      // first products
	localparam int RW  = 2 * C + 3;      // side values, det, line constants
	localparam int NPW = RW + DW;        // numerator products
	localparam int NW  = NPW + 1;        // numerators
	localparam int QW  = C + FRAC_BITS;  // quotient / output width
	localparam int HW  = NW - C;         // numerator bits above the quotient
	localparam int EW  = (RW > 32) ? RW : 33;
	localparam int MW  = 64;

	// ---------------- configuration ----------------
	logic [CFG_DATA_W-1:0] touch_eps_q, parallel_eps_q;
	logic                  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_eps_q    <= TOUCH_EPS_RST;
			parallel_eps_q <= PARALLEL_EPS_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_TOUCH_EPS:    touch_eps_q    <= pwdata;
				REG_PARALLEL_EPS: parallel_eps_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_TOUCH_EPS:    prdata = touch_eps_q;
			REG_PARALLEL_EPS: prdata = parallel_eps_q;
			default:          prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	logic out_vld_q, adv;
	assign adv      = !(out_vld_q && out_stall);
	assign in_stall = !adv;

	function automatic logic [EW-1:0] mag_ext(input logic signed [RW-1:0] v);
		logic signed [EW:0] w;
		w = (EW+1)'(v);
		return EW'((w < 0) ? -w : w);
	endfunction

	// ---------------- stage 1: differences ----------------
	logic vld_s1;
	logic signed [DW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [DW-1:0] e31x_s1, e31y_s1, e41x_s1, e41y_s1;
	logic signed [DW-1:0] e13x_s1, e13y_s1, e23x_s1, e23y_s1;
	logic signed [C-1:0]  x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a1_s1   <= DW'(a_end_y) - DW'(a_start_y);
			b1_s1   <= DW'(a_start_x) - DW'(a_end_x);
			a2_s1   <= DW'(b_end_y) - DW'(b_start_y);
			b2_s1   <= DW'(b_start_x) - DW'(b_end_x);
			e31x_s1 <= DW'(b_start_x) - DW'(a_start_x);
			e31y_s1 <= DW'(b_start_y) - DW'(a_start_y);
			e41x_s1 <= DW'(b_end_x) - DW'(a_start_x);
			e41y_s1 <= DW'(b_end_y) - DW'(a_start_y);
			e13x_s1 <= DW'(a_start_x) - DW'(b_start_x);
			e13y_s1 <= DW'(a_start_y) - DW'(b_start_y);
			e23x_s1 <= DW'(a_end_x) - DW'(b_start_x);
			e23y_s1 <= DW'(a_end_y) - DW'(b_start_y);
			x1_s1   <= a_start_x;
			y1_s1   <= a_start_y;
			x2_s1   <= a_end_x;
			y2_s1   <= a_end_y;
			x3_s1   <= b_start_x;
			y3_s1   <= b_start_y;
			x4_s1   <= b_end_x;
			y4_s1   <= b_end_y;
		end
	end

	// ---------------- stage 2: products ----------------
	logic vld_s2;
	logic signed [DW-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [PW-1:0] pr1a_s2, pr1b_s2, pr2a_s2, pr2b_s2;
	logic signed [PW-1:0] pr3a_s2, pr3b_s2, pr4a_s2, pr4b_s2;
	logic signed [PW-1:0] pd1_s2, pd2_s2, pc1a_s2, pc1b_s2, pc2a_s2, pc2b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a1_s2   <= a1_s1;
			b1_s2   <= b1_s1;
			a2_s2   <= a2_s1;
			b2_s2   <= b2_s1;
			pr3a_s2 <= PW'(a1_s1) * PW'(e31x_s1);
			pr3b_s2 <= PW'(b1_s1) * PW'(e31y_s1);
			pr4a_s2 <= PW'(a1_s1) * PW'(e41x_s1);
			pr4b_s2 <= PW'(b1_s1) * PW'(e41y_s1);
			pr1a_s2 <= PW'(a2_s1) * PW'(e13x_s1);
			pr1b_s2 <= PW'(b2_s1) * PW'(e13y_s1);
			pr2a_s2 <= PW'(a2_s1) * PW'(e23x_s1);
			pr2b_s2 <= PW'(b2_s1) * PW'(e23y_s1);
			pd1_s2  <= PW'(a1_s1) * PW'(b2_s1);
			pd2_s2  <= PW'(a2_s1) * PW'(b1_s1);
			pc1a_s2 <= PW'(x2_s1) * PW'(y1_s1);
			pc1b_s2 <= PW'(x1_s1) * PW'(y2_s1);
			pc2a_s2 <= PW'(x4_s1) * PW'(y3_s1);
			pc2b_s2 <= PW'(x3_s1) * PW'(y4_s1);
		end
	end

	// ---------------- stage 3: side values, det, line constants ----------------
	logic vld_s3;
	logic signed [DW-1:0] a1_s3, b1_s3, a2_s3, b2_s3;
	logic signed [RW-1:0] r1_s3, r2_s3, r3_s3, r4_s3, det_s3, c1_s3, c2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a1_s3  <= a1_s2;
			b1_s3  <= b1_s2;
			a2_s3  <= a2_s2;
			b2_s3  <= b2_s2;
			r1_s3  <= RW'(pr1a_s2) + RW'(pr1b_s2);
			r2_s3  <= RW'(pr2a_s2) + RW'(pr2b_s2);
			r3_s3  <= RW'(pr3a_s2) + RW'(pr3b_s2);
			r4_s3  <= RW'(pr4a_s2) + RW'(pr4b_s2);
			det_s3 <= RW'(pd1_s2) - RW'(pd2_s2);
			c1_s3  <= RW'(pc1a_s2) - RW'(pc1b_s2);
			c2_s3  <= RW'(pc2a_s2) - RW'(pc2b_s2);
		end
	end

	// ---------------- stage 4: numerator products, side checks ----------------
	logic vld_s4, same_s4, detbad_s4, z12_s4, z34_s4, big12_s4, big34_s4;
	logic [31:0] m1_s4, m2_s4, m3_s4, m4_s4;
	logic signed [NPW-1:0] nxa_s4, nxb_s4, nya_s4, nyb_s4;
	logic signed [RW-1:0]  det_s4;
	logic [EW-1:0] m1_c, m2_c, m3_c, m4_c, md_c;
	logic same12_c, same34_c;

	always_comb begin
		m1_c = mag_ext(r1_s3);
		m2_c = mag_ext(r2_s3);
		m3_c = mag_ext(r3_s3);
		m4_c = mag_ext(r4_s3);
		md_c = mag_ext(det_s3);
		same12_c = (r1_s3 != 0) && (r2_s3 != 0) && (r1_s3[RW-1] == r2_s3[RW-1]);
		same34_c = (r3_s3 != 0) && (r4_s3 != 0) && (r3_s3[RW-1] == r4_s3[RW-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nxa_s4    <= NPW'(b1_s3) * NPW'(c2_s3);
			nxb_s4    <= NPW'(b2_s3) * NPW'(c1_s3);
			nya_s4    <= NPW'(a2_s3) * NPW'(c1_s3);
			nyb_s4    <= NPW'(a1_s3) * NPW'(c2_s3);
			det_s4    <= det_s3;
			same_s4   <= same12_c || same34_c;
			detbad_s4 <= (det_s3 == 0) || (md_c < EW'(parallel_eps_q));
			z12_s4    <= (m1_c == 0) || (m2_c == 0);
			z34_s4    <= (m3_c == 0) || (m4_c == 0);
			big12_s4  <= (m1_c[EW-1:32] != 0) || (m2_c[EW-1:32] != 0);
			big34_s4  <= (m3_c[EW-1:32] != 0) || (m4_c[EW-1:32] != 0);
			m1_s4     <= m1_c[31:0];
			m2_s4     <= m2_c[31:0];
			m3_s4     <= m3_c[31:0];
			m4_s4     <= m4_c[31:0];
		end
	end

	// ---------------- stage 5: touch test, numerators ----------------
	logic vld_s5, hit_s5;
	logic signed [NW-1:0] num_s5 [2];
	logic signed [RW-1:0] det_s5;
	logic [MW-1:0] p12_c, p34_c;
	logic bel12_c, bel34_c;

	always_comb begin
		p12_c   = MW'(m1_s4) * MW'(m2_s4);
		p34_c   = MW'(m3_s4) * MW'(m4_s4);
		bel12_c = z12_s4 ? (touch_eps_q != 0)
		                 : (!big12_s4 && (p12_c < MW'(touch_eps_q)));
		bel34_c = z34_s4 ? (touch_eps_q != 0)
		                 : (!big34_s4 && (p34_c < MW'(touch_eps_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s5    <= !same_s4 && !(bel12_c && bel34_c) && !detbad_s4;
			num_s5[0] <= NW'(nxa_s4) - NW'(nxb_s4);
			num_s5[1] <= NW'(nya_s4) - NW'(nyb_s4);
			det_s5    <= det_s4;
		end
	end

	// ---------------- stage 6: divider set-up ----------------
	// dv_*_s[k] is the state ahead of quotient bit k; index QW is the finished quotient
	logic            dv_vld_s [QW+1];
	logic            dv_hit_s [QW+1];
	logic [RW-1:0]   dv_den_s [QW+1];
	logic            dv_neg_s [QW+1][2];
	logic            dv_ovf_s [QW+1][2];
	logic [RW-1:0]   dv_rem_s [QW+1][2];
	logic [QW-1:0]   dv_nlo_s [QW+1][2];
	logic [QW-1:0]   dv_quo_s [QW+1][2];

	logic [RW-1:0]    dmag_c;
	logic [NW-1:0]    nmag_c [2];
	logic [NW+FRAC_BITS-1:0] nf_c [2];
	logic [HW-1:0]    nhi_c [2];

	always_comb begin
		dmag_c = RW'(mag_ext(det_s5));
		for (int l = 0; l < 2; l++) begin
			nmag_c[l] = NW'((num_s5[l] < 0) ? -num_s5[l] : num_s5[l]);
			nf_c[l]   = (NW+FRAC_BITS)'(nmag_c[l]) << FRAC_BITS;
			nhi_c[l]  = nf_c[l][NW+FRAC_BITS-1:QW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_vld_s[0] <= 1'b0;
		else if (adv) dv_vld_s[0] <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_hit_s[0] <= hit_s5;
			dv_den_s[0] <= dmag_c;
			for (int l = 0; l < 2; l++) begin
				dv_neg_s[0][l] <= num_s5[l][NW-1] ^ det_s5[RW-1];
				// quotient of 2^QW or more saturates whatever the sign
				dv_ovf_s[0][l] <= nhi_c[l] >= HW'(dmag_c);
				dv_rem_s[0][l] <= nhi_c[l][RW-1:0];
				dv_nlo_s[0][l] <= nf_c[l][QW-1:0];
				dv_quo_s[0][l] <= '0;
			end
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [RW:0] trial [2];
		logic        ge [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l] = {dv_rem_s[k][l], dv_nlo_s[k][l][QW-1]};
				ge[l]    = trial[l] >= {1'b0, dv_den_s[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[k+1] <= 1'b0;
			else if (adv) dv_vld_s[k+1] <= dv_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_hit_s[k+1] <= dv_hit_s[k];
				dv_den_s[k+1] <= dv_den_s[k];
				for (int l = 0; l < 2; l++) begin
					dv_neg_s[k+1][l] <= dv_neg_s[k][l];
					dv_ovf_s[k+1][l] <= dv_ovf_s[k][l];
					dv_rem_s[k+1][l] <= ge[l] ? RW'(trial[l] - {1'b0, dv_den_s[k]})
					                          : RW'(trial[l]);
					dv_nlo_s[k+1][l] <= dv_nlo_s[k][l] << 1;
					dv_quo_s[k+1][l] <= {dv_quo_s[k][l][QW-2:0], ge[l]};
				end
			end
		end
	end

	// ---------------- output: sign and saturation ----------------
	localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};

	logic [QW-1:0] res_c [2];
	logic [QW-1:0] qs_c  [2];
	logic          status_q;
	logic [QW-1:0] hit_x_q, hit_y_q;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (dv_neg_s[QW][l]) begin
				qs_c[l]  = (dv_ovf_s[QW][l] || dv_quo_s[QW][l] > LIM_NEG)
				           ? LIM_NEG : dv_quo_s[QW][l];
				res_c[l] = -qs_c[l];
			end else begin
				qs_c[l]  = (dv_ovf_s[QW][l] || dv_quo_s[QW][l] > LIM_POS)
				           ? LIM_POS : dv_quo_s[QW][l];
				res_c[l] = qs_c[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (adv) out_vld_q <= dv_vld_s[QW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= dv_hit_s[QW];
			hit_x_q  <= dv_hit_s[QW] ? res_c[0] : '0;
			hit_y_q  <= dv_hit_s[QW] ? res_c[1] : '0;
		end
	end

	assign out_valid = out_vld_q;
	assign status    = status_q;
	assign hit_x     = hit_x_q;
	assign hit_y     = hit_y_q;

	// ---------------- checks ----------------
	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> hit_x == 0 && hit_y == 0)
		else $error("no-hit result carries a nonzero point");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s1)
		else $error("accepted item missing from first stage");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vld_s1) && $stable(dv_vld_s[0]))
		else $error("pipeline moved while the output was held");

endmodule

>>> test/tb.sv
// Self-checking bench for segment_intersection_2d: directed table, then random
// segment pairs under varied idling and a long output hold-off.
// Depends on segisect_pkg and the segment_intersection_2d RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import segisect_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int HB = CB + FB;
	localparam int LATENCY = 7 + CB + FB;
	localparam int WATCHDOG = 20000;

	typedef logic signed [CB-1:0] coord_t;
	typedef struct {
		coord_t c[8];
	} pair_t;
	typedef struct {
		logic st;
		logic signed [HB-1:0] x;
		logic signed [HB-1:0] y;
	} hit_t;
	typedef struct {
		pair_t p;
		logic  known;
		hit_t  h;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	coord_t c_in[8];
	logic st_o;
	logic signed [HB-1:0] hx_o, hy_o;
	logic psel, penable, pwrite, pready;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata, prdata;

	logic [31:0] touch_eps, parallel_eps;
	hit_t hit_queue[$];
	row_t rows[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 0;

	segment_intersection_2d DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_start_x(c_in[0]), .a_start_y(c_in[1]), .a_end_x(c_in[2]), .a_end_y(c_in[3]),
		.b_start_x(c_in[4]), .b_start_y(c_in[5]), .b_end_x(c_in[6]), .b_end_y(c_in[7]),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(st_o), .hit_x(hx_o), .hit_y(hy_o),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// (num << FB) / den truncated toward zero, saturated to HB bits
	function automatic logic signed [HB-1:0] fix_quot(logic signed [127:0] num,
			logic signed [63:0] den);
		logic signed [159:0] q;
		q = ($signed({{32{num[127]}}, num}) <<< FB) / den;
		if (q > ((160'sd1 <<< (HB-1)) - 1)) return {1'b0, {(HB-1){1'b1}}};
		if (q < -(160'sd1 <<< (HB-1))) return {1'b1, {(HB-1){1'b0}}};
		return q[HB-1:0];
	endfunction

	function automatic bit same_sign(logic signed [63:0] p, logic signed [63:0] q);
		return p != 0 && q != 0 && (p[63] == q[63]);
	endfunction

	function automatic bit under_touch(logic signed [63:0] p, logic signed [63:0] q);
		logic [63:0] mp, mq;
		mp = p < 0 ? -p : p;
		mq = q < 0 ? -q : q;
		if (mp == 0 || mq == 0) return touch_eps > 0;
		if (mp[63:32] != 0 || mq[63:32] != 0) return 0;
		return mp * mq < {32'd0, touch_eps};
	endfunction

	function automatic hit_t crossing(pair_t p);
		logic signed [63:0] x1, y1, x2, y2, x3, y3, x4, y4;
		logic signed [63:0] a1, b1, c1, a2, b2, c2, r1, r2, r3, r4, det, mdet;
		logic signed [127:0] nx, ny;
		hit_t h;
		h = '{0, 0, 0};
		x1 = p.c[0]; y1 = p.c[1]; x2 = p.c[2]; y2 = p.c[3];
		x3 = p.c[4]; y3 = p.c[5]; x4 = p.c[6]; y4 = p.c[7];
		a1 = y2 - y1; b1 = x1 - x2; c1 = x2 * y1 - x1 * y2;
		r3 = a1 * x3 + b1 * y3 + c1; r4 = a1 * x4 + b1 * y4 + c1;
		if (same_sign(r3, r4)) return h;
		a2 = y4 - y3; b2 = x3 - x4; c2 = x4 * y3 - x3 * y4;
		r1 = a2 * x1 + b2 * y1 + c2; r2 = a2 * x2 + b2 * y2 + c2;
		if (same_sign(r1, r2)) return h;
		if (under_touch(r1, r2) && under_touch(r3, r4)) return h;
		det = a1 * b2 - a2 * b1;
		mdet = det < 0 ? -det : det;
		if (det == 0 || mdet < $signed({32'd0, parallel_eps})) return h;
		nx = 128'(b1) * 128'(c2) - 128'(b2) * 128'(c1);
		ny = 128'(a2) * 128'(c1) - 128'(a1) * 128'(c2);
		h.st = 1;
		h.x = fix_quot(nx, det);
		h.y = fix_quot(ny, det);
		return h;
	endfunction

	function automatic pair_t mk(int v0, int v1, int v2, int v3, int v4, int v5,
			int v6, int v7);
		pair_t p;
		p.c = '{coord_t'(v0), coord_t'(v1), coord_t'(v2), coord_t'(v3),
			coord_t'(v4), coord_t'(v5), coord_t'(v6), coord_t'(v7)};
		return p;
	endfunction

	function automatic coord_t rnd_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 1) ? 32767 : -32768);
			2: return coord_t'(int'($urandom_range(0, 40)) - 20);
			default: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
		endcase
	endfunction

	// mostly crossing pairs: A's ends straddle a point, B's ends straddle it too
	function automatic pair_t rnd_pair();
		pair_t p;
		int cx, cy;
		for (int i = 0; i < 8; i++) p.c[i] = rnd_coord();
		if ($urandom_range(0, 3) != 0) begin
			cx = int'(rnd_coord()) / 2; cy = int'(rnd_coord()) / 2;
			p.c[2] = coord_t'(2 * cx - int'(p.c[0]) / 2 * 2 + $urandom_range(0, 1));
			p.c[3] = coord_t'(2 * cy - int'(p.c[1]) / 2 * 2);
			p.c[6] = coord_t'(2 * cx - int'(p.c[4]) / 2 * 2);
			p.c[7] = coord_t'(2 * cy - int'(p.c[5]) / 2 * 2 + $urandom_range(0, 1));
		end
		return p;
	endfunction

	task automatic add_row(pair_t p, logic known, hit_t h);
		rows.insert(rows.size(), '{p, known, h});
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= CFG_ADDR_W'(4 * int'(idx)); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_TOUCH_EPS) touch_eps = val;
		else parallel_eps = val;
		// read the register back on the unchanged address
		@(posedge clk);
		if (prdata !== val || pready !== 1'b1) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register readback: exp %h got %h (ready %b)", val, prdata, pready);
		end
	endtask

	task automatic send_item(pair_t p);
		while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		c_in <= p.c;
		hit_queue.insert(hit_queue.size(), crossing(p));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (hit_queue.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// receiver
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (hit_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item: %0b %0d %0d", st_o, hx_o, hy_o);
			end else begin
				hit_t e;
				e = hit_queue.pop_front();
				if (e.st !== st_o || e.x !== hx_o || e.y !== hy_o) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0b %0d %0d got %0b %0d %0d",
							e.st, e.x, e.y, st_o, hx_o, hy_o);
				end
			end
		end
		if (hold_off) out_stall <= 1;
		else out_stall <= recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct;
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n || psel)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		hit_t pr;
		int phase;
		in_valid = 0; out_stall = 0; psel = 0; penable = 0; pwrite = 0;
		paddr = '0; pwdata = '0;
		for (int i = 0; i < 8; i++) c_in[i] = '0;
		touch_eps = TOUCH_EPS_RST; parallel_eps = PARALLEL_EPS_RST;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// crossings at the origin and at (2, 2), results known by eye
		add_row(mk(-4, 0, 4, 0, 0, -4, 0, 4), 1, '{1, 0, 0});
		add_row(mk(0, 0, 4, 4, 0, 4, 4, 0), 1, '{1, 2 <<< FB, 2 <<< FB});
		// both on one side
		add_row(mk(0, 0, 10, 0, 0, 1, 10, 5), 1, '{0, 0, 0});
		add_row(mk(0, 1, 10, 5, 0, 0, 10, 0), 1, '{0, 0, 0});
		// parallel and collinear
		add_row(mk(0, 0, 10, 0, 0, 0, 5, 0), 1, '{0, 0, 0});
		add_row(mk(0, 0, 10, 10, 1, 1, 20, 20), 1, '{0, 0, 0});
		// segments reaching the coordinate extremes
		add_row(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
			0, '{0, 0, 0});
		add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
			1, '{0, 0, 0});
		add_row(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 0, '{0, 0, 0});
		add_row(mk(-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767),
			0, '{0, 0, 0});
		// endpoint touching the other line, shared endpoint, fractional crossings
		add_row(mk(0, 0, 4, 0, 2, 0, 2, 5), 0, '{0, 0, 0});
		add_row(mk(0, 0, 4, 4, 4, 4, 8, 0), 0, '{0, 0, 0});
		add_row(mk(0, 0, 3, 1, 0, 1, 3, 0), 0, '{0, 0, 0});
		add_row(mk(-1, -1, 2, 1, 1, -3, -2, 5), 0, '{0, 0, 0});
		foreach (rows[i]) begin
			send_item(rows[i].p);
			pr = hit_queue[$];
			if (rows[i].known && (pr.st !== rows[i].h.st || pr.x !== rows[i].h.x ||
					pr.y !== rows[i].h.y)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row %0d: exp %0b %0d %0d got %0b %0d %0d", i,
						rows[i].h.st, rows[i].h.x, rows[i].h.y, pr.st, pr.x, pr.y);
			end
		end
		drain();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin cfg_write(REG_TOUCH_EPS, 0); cfg_write(REG_PARALLEL_EPS, 0); end
				1: begin cfg_write(REG_TOUCH_EPS, 32'hFFFF_FFFF); cfg_write(REG_PARALLEL_EPS, 5); end
				2: begin cfg_write(REG_TOUCH_EPS, $urandom_range(0, 5000));
					cfg_write(REG_PARALLEL_EPS, 32'hFFFF_FFFF); end
				3: begin cfg_write(REG_TOUCH_EPS, 1000); cfg_write(REG_PARALLEL_EPS, 100); end
				4: begin cfg_write(REG_TOUCH_EPS, 1); cfg_write(REG_PARALLEL_EPS, 1); end
				default: begin cfg_write(REG_TOUCH_EPS, $urandom);
					cfg_write(REG_PARALLEL_EPS, $urandom_range(0, 64)); end
			endcase
			send_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? 61 : 0;
			recv_stall_pct = (phase % 4 == 2) ? 61 : (phase % 4 == 3) ? 20 : 0;
			if (phase % 4 == 3) send_idle_pct = 20;
			if (phase == 4) begin
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int n = 0; n < 190; n++) send_item(rnd_pair());
			recv_stall_pct = 0;
			drain();
		end

		if (mismatches == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule

>>> segment_intersection_2d.f
hdl/segisect_pkg.sv
hdl/segment_intersection_2d.sv
test/tb.sv
